// ===== hw/rtl/msr_pkg.sv =====
// Shared types and constants for the sample-run median block.
package msr_pkg;

	localparam int SAMPLE_W = 32;
	localparam int COUNT_W  = 10;

	typedef logic [SAMPLE_W-1:0] sample_t;

	// What every cell of the chain does in a cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT
	} cell_op_t;

	// Broadcast from the controller to the whole chain
	typedef struct packed {
		cell_op_t op;
		sample_t  sample;
	} cell_ctrl_t;

endpackage

// ===== hw/rtl/msr_cell.sv =====
// One cell of the sorting chain: holds one sample of the ascending run.
module msr_cell (
	input  logic               clk,
	input  msr_pkg::cell_ctrl_t ctrl,
	input  msr_pkg::sample_t   left_value,
	input  logic               left_gt,
	input  msr_pkg::sample_t   right_value,
	input  logic               beyond,
	output msr_pkg::sample_t   value,
	output logic               gt
);
	import msr_pkg::*;

	sample_t value_q;

	assign value = value_q;
	// held sample is larger than the broadcast sample
	assign gt    = value_q > ctrl.sample;

	// insert: make room by taking the left neighbour, or take the new sample here;
	// shift: move one place towards the head for read-out
	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_INSERT: begin
				if (left_gt) begin
					value_q <= left_value;
				end else if (gt || beyond) begin
					value_q <= ctrl.sample;
				end
			end
			CELL_SHIFT: begin
				value_q <= right_value;
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

endmodule

// ===== hw/rtl/msr_chain.sv =====
// Row of sorting cells with neighbour wiring and per-cell occupancy.
module msr_chain #(
	parameter int DEPTH  = 512,
	parameter int FILL_W = 10
) (
	input  logic                clk,
	input  msr_pkg::cell_ctrl_t ctrl,
	input  logic [FILL_W-1:0]   fill,
	output msr_pkg::sample_t    head
);
	import msr_pkg::*;

	sample_t value [DEPTH];
	logic    gt    [DEPTH];

	assign head = value[0];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		sample_t left_value;
		logic    left_gt;
		sample_t right_value;
		logic    beyond;

		// cells at or past the fill level hold nothing of this run
		assign beyond = FILL_W'(i) >= fill;

		if (i == 0) begin : g_first
			assign left_value = '0;
			assign left_gt    = 1'b0;
		end else begin : g_mid
			assign left_value = value[i-1];
			assign left_gt    = gt[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_value = '0;
		end else begin : g_body
			assign right_value = value[i+1];
		end

		msr_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.left_value  (left_value),
			.left_gt     (left_gt),
			.right_value (right_value),
			.beyond      (beyond),
			.value       (value[i]),
			.gt          (gt[i])
		);
	end

endmodule

// ===== hw/rtl/median_of_sample_run.sv =====
// Top level: running insertion sort of a sample run with median read-out.
//
// Samples are taken one per clock while busy is low; each is inserted in
// order into a chain of CAPACITY cells in the cycle of its transfer. A sample
// arriving with the store full is dropped and overflow is reported. On the
// sample marked last, busy rises and the chain shifts one cell per cycle
// towards its head until the middle element(s) have passed, then the median
// is registered in a finish state before busy falls; done pulses for one
// cycle with median, count and overflow in the cycle busy falls, and a new run
// may start in that same cycle. Results cannot be held off: done is a single
// cycle strobe and the receiver must take it then.
module median_of_sample_run #(
	parameter int CAPACITY = 512
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [msr_pkg::SAMPLE_W-1:0] sample,
	input  logic                        last,
	output logic                        done,
	output logic [msr_pkg::SAMPLE_W-1:0] median,
	output logic [msr_pkg::COUNT_W-1:0]  count,
	output logic                        overflow
);
	import msr_pkg::*;

	localparam int FILL_W = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t             state_q;
	logic [FILL_W-1:0]  fill_q;
	logic [FILL_W-1:0]  idx_q;
	logic               ovf_q;
	sample_t            a_q;
	sample_t            b_q;
	logic               done_q;
	sample_t            median_q;
	logic [COUNT_W-1:0] count_q;
	logic               overflow_q;

	logic                       accept;
	logic                       room;
	logic [FILL_W-1:0]          lo_idx;
	logic [FILL_W-1:0]          hi_idx;
	logic [SAMPLE_W:0]          pair_sum;
	logic [FILL_W+COUNT_W-1:0]  count_wide;
	cell_ctrl_t                 ctrl;
	sample_t                    head;

	assign busy   = state_q != S_IDLE;
	assign accept = start && !busy;
	assign room   = fill_q < FILL_W'(CAPACITY);

	// middle positions of the sorted run; equal for an odd count
	assign lo_idx = (fill_q - 1'b1) >> 1;
	assign hi_idx = fill_q >> 1;

	assign pair_sum   = {1'b0, a_q} + {1'b0, b_q};
	assign count_wide = {{COUNT_W{1'b0}}, fill_q};

	// chain command
	always_comb begin
		ctrl.sample = sample;
		if (state_q == S_DRAIN) begin
			ctrl.op = CELL_SHIFT;
		end else if (accept && room) begin
			ctrl.op = CELL_INSERT;
		end else begin
			ctrl.op = CELL_HOLD;
		end
	end

	msr_chain #(
		.DEPTH  (CAPACITY),
		.FILL_W (FILL_W)
	) u_chain (
		.clk  (clk),
		.ctrl (ctrl),
		.fill (fill_q),
		.head (head)
	);

	// run control and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fill_q     <= '0;
			idx_q      <= '0;
			ovf_q      <= 1'b0;
			a_q        <= '0;
			b_q        <= '0;
			done_q     <= 1'b0;
			median_q   <= '0;
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (room) begin
							fill_q <= fill_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (last) begin
							idx_q   <= '0;
							state_q <= S_DRAIN;
						end
					end
				end
				S_DRAIN: begin
					// head shows sorted element idx_q this cycle
					if (idx_q == lo_idx) begin
						a_q <= head;
					end
					if (idx_q == hi_idx) begin
						b_q     <= head;
						state_q <= S_FINISH;
					end
					idx_q <= idx_q + 1'b1;
				end
				S_FINISH: begin
					median_q   <= pair_sum[SAMPLE_W:1];
					count_q    <= count_wide[COUNT_W-1:0];
					overflow_q <= ovf_q;
					done_q     <= 1'b1;
					fill_q     <= '0;
					ovf_q      <= 1'b0;
					state_q    <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done     = done_q;
	assign median   = median_q;
	assign count    = count_q;
	assign overflow = overflow_q;

endmodule

// ===== hw/rtl/msr_checker.sv =====
// Port-level checks for the sample-run median block, bound to the top level.
module msr_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic last,
	input logic done
);

	// result strobe lasts one cycle
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// a transfer without last gives no result
	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !last) |=> !done)
		else $error("result after a sample not marked last");

	// the last sample starts the read-out
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last) |=> busy)
		else $error("busy not raised after last sample");

	// a result comes only as the read-out ends
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result outside the end of a read-out");

endmodule

bind median_of_sample_run msr_checker u_msr_checker (.*);

// ===== tb/sv/median_checker.sv =====
// Checker for the sample-run median block: predicts each median and compares results.
`timescale 1ns / 100ps

module median_checker #(
	parameter int CAPACITY = 512
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic [msr_pkg::SAMPLE_W-1:0] sample,
	input  logic                         last,
	input  logic                         done,
	input  logic [msr_pkg::SAMPLE_W-1:0] median,
	input  logic [msr_pkg::COUNT_W-1:0]  count,
	input  logic                         overflow,
	output int                           fail_count,
	output int                           pending_count,
	output int                           checked_count
);
	import msr_pkg::*;

	typedef struct {
		sample_t             median;
		logic [COUNT_W-1:0]  count;
		logic                dropped;
	} run_summary_t;

	// Predicted state of the run in progress
	sample_t      run_store [CAPACITY];
	int           run_fill;
	logic         run_dropped;
	run_summary_t summary_q [$];

	// Middle value, or floor of the mean of the two middle values in 33 bits
	function automatic sample_t middle_of_run();
		logic [SAMPLE_W:0] pair_sum;
		if (run_fill % 2 == 1)
			return run_store[(run_fill - 1) / 2];
		pair_sum = {1'b0, run_store[run_fill/2 - 1]} + {1'b0, run_store[run_fill/2]};
		return pair_sum[SAMPLE_W:1];
	endfunction

	// Insert one sample in order; on the closing sample queue the summary
	task automatic take_sample(input sample_t value, input logic closing);
		int           pos;
		run_summary_t summary;
		if (run_fill < CAPACITY) begin
			pos = run_fill;
			while (pos > 0 && run_store[pos-1] > value) begin
				run_store[pos] = run_store[pos-1];
				pos--;
			end
			run_store[pos] = value;
			run_fill++;
		end else begin
			run_dropped = 1'b1;
		end
		if (closing) begin
			summary.median  = middle_of_run();
			summary.count   = COUNT_W'(run_fill);
			summary.dropped = run_dropped;
			summary_q.push_back(summary);
			run_fill    = 0;
			run_dropped = 1'b0;
		end
	endtask

	// Compare one strobed result with the oldest expectation
	task automatic check_result();
		run_summary_t want;
		if (summary_q.size() == 0) begin
			$display("%0t: result with nothing expected: median %h count %0d overflow %b",
				$time, median, count, overflow);
			fail_count++;
			return;
		end
		want = summary_q.pop_front();
		checked_count++;
		if (median !== want.median) begin
			$display("%0t: median expected %h, got %h", $time, want.median, median);
			fail_count++;
		end
		if (count !== want.count) begin
			$display("%0t: count expected %0d, got %0d", $time, want.count, count);
			fail_count++;
		end
		if (overflow !== want.dropped) begin
			$display("%0t: overflow expected %b, got %b", $time, want.dropped, overflow);
			fail_count++;
		end
	endtask

	// Watch both sides at each edge; inputs and outputs hold their pre-edge values here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_fill    = 0;
			run_dropped = 1'b0;
			summary_q.delete();
		end else begin
			if (done === 1'b1)
				check_result();
			if (start && busy === 1'b0)
				take_sample(sample, last);
		end
		pending_count = summary_q.size();
	end

	initial begin
		fail_count    = 0;
		pending_count = 0;
		checked_count = 0;
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the testbench: clock, reset, sample-run stimulus and the verdict.
`timescale 1ns / 100ps

module testbench;
	import msr_pkg::*;

	localparam int CAPACITY    = 512;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = CAPACITY/2 + 40;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [SAMPLE_W-1:0] sample;
	logic               last;
	logic               done;
	logic [SAMPLE_W-1:0] median;
	logic [COUNT_W-1:0]  count;
	logic               overflow;

	int fail_count;
	int pending_count;
	int checked_count;
	int cycles;
	int samples_sent;
	int runs_sent;
	int runs_overfull;

	median_of_sample_run #(.CAPACITY(CAPACITY)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.sample   (sample),
		.last     (last),
		.done     (done),
		.median   (median),
		.count    (count),
		.overflow (overflow)
	);

	median_checker #(.CAPACITY(CAPACITY)) median_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.sample        (sample),
		.last          (last),
		.done          (done),
		.median        (median),
		.count         (count),
		.overflow      (overflow),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.checked_count (checked_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d medians outstanding", $time, pending_count);
			$display("FAIL");
			$finish;
		end
	end

	// Sample values: full range, extremes, near the top, and a narrow band for duplicates
	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return sample_t'('1) - sample_t'($urandom_range(0, 15));
			3, 4:    return sample_t'($urandom_range(0, 15));
			default: return $urandom();
		endcase
	endfunction

	// One transfer: hold start until busy is low at an edge
	task automatic send_sample(input sample_t value, input logic closing);
		start  <= 1'b1;
		sample <= value;
		last   <= closing;
		do @(posedge clk); while (busy !== 1'b0);
		samples_sent++;
		if (closing)
			runs_sent++;
	endtask

	// Sender idle cycles, each taken with the given chance in a hundred
	task automatic idle_gap(input int idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			start  <= 1'b0;
			sample <= $urandom();
			last   <= 1'($urandom());
			@(posedge clk);
		end
	endtask

	task automatic drive_run(input int len, input int idle_pct);
		for (int i = 0; i < len; i++) begin
			send_sample(pick_sample(), i == len - 1);
			idle_gap(idle_pct);
		end
		if (len > CAPACITY)
			runs_overfull++;
	endtask

	initial begin
		int idle_pct;
		int phase_items;
		int run_len;

		samples_sent  = 0;
		runs_sent     = 0;
		runs_overfull = 0;
		arst_n        = 1'b0;
		start         = 1'b0;
		sample        = '0;
		last          = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single-sample runs at both extremes
		send_sample('0, 1'b1);
		send_sample('1, 1'b1);
		// Even counts at the top of the range: sum needs the 33rd bit
		send_sample('1, 1'b0);
		send_sample('1, 1'b1);
		send_sample('0, 1'b0);
		send_sample('1, 1'b1);
		// Descending arrival, then duplicates with an even count
		send_sample(32'd30, 1'b0);
		send_sample(32'd20, 1'b0);
		send_sample(32'd10, 1'b1);
		send_sample(32'd5, 1'b0);
		send_sample(32'd5, 1'b0);
		send_sample(32'd1, 1'b0);
		send_sample(32'd9, 1'b1);
		// Odd pair sum rounds down; ascending arrival
		send_sample(32'd1, 1'b0);
		send_sample(32'd2, 1'b1);
		send_sample(32'd7, 1'b0);
		send_sample(32'd8, 1'b0);
		send_sample(32'd9, 1'b1);

		// Random runs: no idling, sender mostly idle, sender rarely idle
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 0 : (phase == 1) ? 88 : 7;
			// Long runs: exactly full with no idling, past capacity in the last phase
			case (phase)
				0:       drive_run(CAPACITY, idle_pct);
				2:       drive_run(CAPACITY + $urandom_range(1, 4), idle_pct);
				default: ;
			endcase
			phase_items = 0;
			while (phase_items < 60) begin
				run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
					: $urandom_range(1, 12);
				drive_run(run_len, idle_pct);
				phase_items += run_len;
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Sent %0d samples in %0d runs, %0d of them past capacity",
			samples_sent, runs_sent, runs_overfull);
		$display("Compared %0d medians under three sender idling patterns", checked_count);
		if (fail_count == 0 && pending_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
